// File: rtl/point_segment_distance_defines.svh
// assertion helpers for the point to segment distance block
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS
`define PSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PSD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PSD_ASSERT(label, clk, rst, prop, msg)
`define PSD_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

// File: rtl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and fixed widths of the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int FIELD_W   = 16;   // width of every coordinate field
   localparam int H_BITS    = 16;   // fraction bits of the projection factor
   localparam int DIST_BITS = 25;   // width of the distance result

   typedef struct packed {
      logic signed [FIELD_W-1:0] point_x;
      logic signed [FIELD_W-1:0] point_y;
      logic signed [FIELD_W-1:0] start_x;
      logic signed [FIELD_W-1:0] start_y;
      logic signed [FIELD_W-1:0] end_x;
      logic signed [FIELD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 degenerate;
   } rsp_type;

endpackage

// File: rtl/psd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, for num < den.
// ----------------------------------------------------------------------------
module psd_div #(
   parameter int DEN_W  = 35,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [DEN_W-1:0]              in_num,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [psd_pkg::H_BITS-1:0]    out_q,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int N   = psd_pkg::H_BITS;
   localparam int R_W = DEN_W + 1;

   logic             valid_ff [N];
   logic [R_W-1:0]   rem_ff   [N];
   logic [N-1:0]     q_ff     [N];
   logic [DEN_W-1:0] den_ff   [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              p_valid;
      logic [R_W-1:0]    p_rem;
      logic [N-1:0]      p_q;
      logic [DEN_W-1:0]  p_den;
      logic [SIDE_W-1:0] p_side;
      logic [R_W-1:0]    rem_sh;
      logic              ge;
      logic [R_W-1:0]    rem_in;
      logic [N-1:0]      q_in;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = {1'b0, in_num};
         assign p_q     = '0;
         assign p_den   = in_den;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_q     = q_ff[k-1];
         assign p_den   = den_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      assign rem_sh = {p_rem[R_W-2:0], 1'b0};
      assign ge     = rem_sh >= {1'b0, p_den};
      assign rem_in = ge ? (rem_sh - {1'b0, p_den}) : rem_sh;
      assign q_in   = {p_q[N-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            den_ff[k]  <= p_den;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_q     = q_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

// File: rtl/psd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
   parameter int RT_W   = 26,
   parameter int SIDE_W = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [2*RT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [RT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int RAD_W = 2 * RT_W;
   localparam int REM_W = RT_W + 3;

   logic              valid_ff [RT_W];
   logic [REM_W-1:0]  rem_ff   [RT_W];
   logic [RT_W-1:0]   root_ff  [RT_W];
   logic [RAD_W-1:0]  rad_ff   [RT_W];
   logic [SIDE_W-1:0] side_ff  [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic              p_valid;
      logic [REM_W-1:0]  p_rem;
      logic [RT_W-1:0]   p_root;
      logic [RAD_W-1:0]  p_rad;
      logic [SIDE_W-1:0] p_side;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [RT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_rad   = in_rad;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_root  = root_ff[k-1];
         assign p_rad   = rad_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh  = {p_rem[REM_W-3:0], p_rad[RAD_W-1:RAD_W-2]};
      assign trial   = {1'b0, p_root, 2'b01};
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
      assign root_in = {p_root[RT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {p_rad[RAD_W-3:0], 2'b00};
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

// File: rtl/point_segment_distance.sv
// path from an accepted req beat to its rsp beat: 4 setup stages,
// 16 divider stages, 6 offset stages, 26 root stages, 1 output register
// throughput: one beat per cycle; the whole pipe holds only while rsp is stalled
// reset: synchronous, active high, clears every valid bit; data registers keep
// their contents
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a point to a 2-D segment, pipelined, unsigned fixed point out.
// ----------------------------------------------------------------------------
`include "point_segment_distance_defines.svh"

module point_segment_distance #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psd_pkg::rsp_type rsp_data
);

   localparam int FW     = psd_pkg::FIELD_W;
   localparam int HB     = psd_pkg::H_BITS;
   localparam int DB     = psd_pkg::DIST_BITS;
   localparam int TAKE   = (COORD_BITS < FW) ? COORD_BITS : FW;
   localparam int AW     = COORD_BITS + 1;
   localparam int P_W    = 2 * AW;
   localparam int NUM_W  = P_W + 1;
   localparam int HW     = HB + 1;
   localparam int HP_W   = HW + 1 + AW;
   localparam int D_W    = HP_W + 1;
   localparam int SHIFT  = HB - FRAC_BITS;
   localparam int SQ_W   = 2 * DB;
   localparam int RT_W   = DB + 1;
   localparam int RAD_W  = 2 * RT_W;
   localparam int SIDE_W = 4 * AW + 3;
   localparam logic [DB-1:0] SAT   = {DB{1'b1}};
   localparam logic [HW-1:0] H_ONE = {1'b1, {HB{1'b0}}};

   logic adv;
   logic out_valid_ff;
   psd_pkg::rsp_type out_data_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---- stage 1: sign extend and take differences
   logic [TAKE-1:0] px_t, py_t, ax_t, ay_t, bx_t, by_t;
   logic signed [AW-1:0] px_e, py_e, ax_e, ay_e, bx_e, by_e;

   assign px_t = req_data.point_x[TAKE-1:0];
   assign py_t = req_data.point_y[TAKE-1:0];
   assign ax_t = req_data.start_x[TAKE-1:0];
   assign ay_t = req_data.start_y[TAKE-1:0];
   assign bx_t = req_data.end_x[TAKE-1:0];
   assign by_t = req_data.end_y[TAKE-1:0];
   assign px_e = {{(AW-TAKE){px_t[TAKE-1]}}, px_t};
   assign py_e = {{(AW-TAKE){py_t[TAKE-1]}}, py_t};
   assign ax_e = {{(AW-TAKE){ax_t[TAKE-1]}}, ax_t};
   assign ay_e = {{(AW-TAKE){ay_t[TAKE-1]}}, ay_t};
   assign bx_e = {{(AW-TAKE){bx_t[TAKE-1]}}, bx_t};
   assign by_e = {{(AW-TAKE){by_t[TAKE-1]}}, by_t};

   logic                 s1_valid_ff;
   logic signed [AW-1:0] s1_apx_ff, s1_apy_ff, s1_abx_ff, s1_aby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_apx_ff <= px_e - ax_e;
         s1_apy_ff <= py_e - ay_e;
         s1_abx_ff <= bx_e - ax_e;
         s1_aby_ff <= by_e - ay_e;
      end
   end

   // ---- stage 2: the four products
   logic                  s2_valid_ff;
   logic signed [P_W-1:0] s2_pxx_ff, s2_pyy_ff, s2_dxx_ff, s2_dyy_ff;
   logic signed [AW-1:0]  s2_apx_ff, s2_apy_ff, s2_abx_ff, s2_aby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pxx_ff <= s1_apx_ff * s1_abx_ff;
         s2_pyy_ff <= s1_apy_ff * s1_aby_ff;
         s2_dxx_ff <= s1_abx_ff * s1_abx_ff;
         s2_dyy_ff <= s1_aby_ff * s1_aby_ff;
         s2_apx_ff <= s1_apx_ff;
         s2_apy_ff <= s1_apy_ff;
         s2_abx_ff <= s1_abx_ff;
         s2_aby_ff <= s1_aby_ff;
      end
   end

   // ---- stage 3: dot products
   logic                    s3_valid_ff;
   logic signed [NUM_W-1:0] s3_num_ff, s3_den_ff;
   logic signed [AW-1:0]    s3_apx_ff, s3_apy_ff, s3_abx_ff, s3_aby_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_num_ff <= $signed({s2_pxx_ff[P_W-1], s2_pxx_ff})
                    + $signed({s2_pyy_ff[P_W-1], s2_pyy_ff});
         s3_den_ff <= $signed({s2_dxx_ff[P_W-1], s2_dxx_ff})
                    + $signed({s2_dyy_ff[P_W-1], s2_dyy_ff});
         s3_apx_ff <= s2_apx_ff;
         s3_apy_ff <= s2_apy_ff;
         s3_abx_ff <= s2_abx_ff;
         s3_aby_ff <= s2_aby_ff;
      end
   end

   // ---- stage 4: clamp decision
   logic                    s4_valid_ff;
   logic [NUM_W-1:0]        s4_num_ff, s4_den_ff;
   logic [SIDE_W-1:0]       s4_side_ff;
   logic                    deg_in, zero_in, one_in;

   assign deg_in  = (s3_den_ff == '0);
   assign zero_in = deg_in || s3_num_ff[NUM_W-1] || (s3_num_ff == '0);
   assign one_in  = !zero_in && (s3_num_ff >= s3_den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_num_ff  <= $unsigned(s3_num_ff);
         s4_den_ff  <= $unsigned(s3_den_ff);
         s4_side_ff <= {s3_apx_ff, s3_apy_ff, s3_abx_ff, s3_aby_ff,
                        deg_in, zero_in, one_in};
      end
   end

   // ---- projection factor divider
   logic              dv_valid;
   logic [HB-1:0]     dv_q;
   logic [SIDE_W-1:0] dv_side;

   psd_div #(
      .DEN_W  (NUM_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   // ---- stage 5: clamped factor
   logic                 s5_valid_ff;
   logic [HW-1:0]        s5_h_ff;
   logic                 s5_deg_ff;
   logic signed [AW-1:0] s5_apx_ff, s5_apy_ff, s5_abx_ff, s5_aby_ff;
   logic [HW-1:0]        h_in;

   always_comb begin
      if (dv_side[1]) begin
         h_in = '0;
      end else if (dv_side[0]) begin
         h_in = H_ONE;
      end else begin
         h_in = {1'b0, dv_q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_h_ff   <= h_in;
         s5_deg_ff <= dv_side[2];
         {s5_apx_ff, s5_apy_ff, s5_abx_ff, s5_aby_ff} <= dv_side[SIDE_W-1:3];
      end
   end

   // ---- stage 6: h * ab per axis
   logic                   s6_valid_ff;
   logic signed [HP_W-1:0] s6_hx_ff, s6_hy_ff;
   logic signed [AW-1:0]   s6_apx_ff, s6_apy_ff;
   logic                   s6_deg_ff;
   logic signed [HW:0]     h_s;

   assign h_s = $signed({1'b0, s5_h_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_hx_ff  <= h_s * s5_abx_ff;
         s6_hy_ff  <= h_s * s5_aby_ff;
         s6_apx_ff <= s5_apx_ff;
         s6_apy_ff <= s5_apy_ff;
         s6_deg_ff <= s5_deg_ff;
      end
   end

   // ---- stage 7: offset ap*2^16 - h*ab
   logic                  s7_valid_ff;
   logic signed [D_W-1:0] s7_dx_ff, s7_dy_ff;
   logic                  s7_deg_ff;
   logic signed [D_W-1:0] apx_sh, apy_sh;

   assign apx_sh = {{(D_W-HB-AW){s6_apx_ff[AW-1]}}, s6_apx_ff, {HB{1'b0}}};
   assign apy_sh = {{(D_W-HB-AW){s6_apy_ff[AW-1]}}, s6_apy_ff, {HB{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_dx_ff  <= apx_sh - $signed({s6_hx_ff[HP_W-1], s6_hx_ff});
         s7_dy_ff  <= apy_sh - $signed({s6_hy_ff[HP_W-1], s6_hy_ff});
         s7_deg_ff <= s6_deg_ff;
      end
   end

   // ---- stage 8: magnitude, truncate to output fraction, saturate
   logic           s8_valid_ff;
   logic [DB-1:0]  s8_mx_ff, s8_my_ff;
   logic           s8_over_ff, s8_deg_ff;
   logic [D_W-1:0] magx, magy, mx_w, my_w;
   logic           ovx, ovy;

   assign magx = s7_dx_ff[D_W-1] ? $unsigned(-s7_dx_ff) : $unsigned(s7_dx_ff);
   assign magy = s7_dy_ff[D_W-1] ? $unsigned(-s7_dy_ff) : $unsigned(s7_dy_ff);
   assign mx_w = magx >> SHIFT;
   assign my_w = magy >> SHIFT;
   assign ovx  = |mx_w[D_W-1:DB];
   assign ovy  = |my_w[D_W-1:DB];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_mx_ff   <= ovx ? SAT : mx_w[DB-1:0];
         s8_my_ff   <= ovy ? SAT : my_w[DB-1:0];
         s8_over_ff <= ovx || ovy;
         s8_deg_ff  <= s7_deg_ff;
      end
   end

   // ---- stage 9: squares
   logic            s9_valid_ff;
   logic [SQ_W-1:0] s9_sx_ff, s9_sy_ff;
   logic            s9_over_ff, s9_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (adv) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_sx_ff   <= s8_mx_ff * s8_mx_ff;
         s9_sy_ff   <= s8_my_ff * s8_my_ff;
         s9_over_ff <= s8_over_ff;
         s9_deg_ff  <= s8_deg_ff;
      end
   end

   // ---- stage 10: sum of squares
   logic             s10_valid_ff;
   logic [RAD_W-1:0] s10_rad_ff;
   logic             s10_over_ff, s10_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (adv) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_rad_ff  <= {{(RAD_W-SQ_W){1'b0}}, s9_sx_ff} + {{(RAD_W-SQ_W){1'b0}}, s9_sy_ff};
         s10_over_ff <= s9_over_ff;
         s10_deg_ff  <= s9_deg_ff;
      end
   end

   // ---- square root
   logic            sq_valid;
   logic [RT_W-1:0] sq_root;
   logic [1:0]      sq_side;

   psd_sqrt #(
      .RT_W   (RT_W),
      .SIDE_W (2)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s10_valid_ff),
      .in_rad    (s10_rad_ff),
      .in_side   ({s10_over_ff, s10_deg_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---- output register
   psd_pkg::rsp_type out_data_in;

   always_comb begin
      out_data_in.degenerate = sq_side[0];
      if (sq_side[1] || sq_root[RT_W-1]) begin
         out_data_in.distance = SAT;
      end else begin
         out_data_in.distance = sq_root[DB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---- checks
   `PSD_ASSERT(a_h_in_range, clock, reset, !s5_valid_ff || (s5_h_ff <= H_ONE), "projection factor above one")
   `PSD_ASSERT(a_deg_h_zero, clock, reset, !(s5_valid_ff && s5_deg_ff) || (s5_h_ff == '0), "zero-length segment with nonzero factor")
   `PSD_ASSERT_NEXT(a_hold_on_stall, clock, reset, !adv, $stable(s5_h_ff) && $stable(s5_valid_ff), "pipe moved during stall")

endmodule
